>>> hw/rtl/psc_pkg.sv
// Package: shared types, constants and codes of the pulse shape classifier.
`default_nettype none
package psc_pkg;

  // Default structure parameters
  localparam int WINDOW_LEN_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 10;

  // Fixed field widths
  localparam int CNT_W      = 16;  // event counters
  localparam int WIDE_W     = 32;  // rate and mean width
  localparam int TIME_W     = 16;  // tick fields
  localparam int PLIM_W     = 16;  // power limits
  localparam int SLIM_W     = 10;  // slope limits
  localparam int LVL_W      = 2;
  localparam int EV_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Divider and product widths
  localparam int PROD_W = 48;          // 16 x 32 product
  localparam int TD_W   = 23;          // 16-bit width times 100
  localparam int DIV_W  = PROD_W + 1;  // width-update numerator
  localparam int DVS_W  = 16;          // every divisor fits here
  localparam int STEP_W = 6;           // holds DIV_W

  // Register reset values and scale constants
  localparam logic [PLIM_W-1:0] POWER_HIGH_RST = 16'd25000;
  localparam logic [PLIM_W-1:0] POWER_LOW_RST  = 16'd2000;
  localparam logic [SLIM_W-1:0] SLOPE_HIGH_RST = 10'd200;
  localparam logic [SLIM_W-1:0] SLOPE_LOW_RST  = 10'd15;
  localparam logic [PLIM_W-1:0] POWER_MAX      = 16'hFFFF;
  localparam logic [16:0]       RATE_SCALE     = 17'd100000;
  localparam logic [6:0]        WIDTH_SCALE    = 7'd100;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POWER_HIGH = 2'd0,
    CFG_POWER_LOW  = 2'd1,
    CFG_SLOPE_HIGH = 2'd2,
    CFG_SLOPE_LOW  = 2'd3
  } cfg_idx_e;

  // Sticky level codes
  typedef enum logic [LVL_W-1:0] {
    LVL_NONE = 2'd0,
    LVL_LOW  = 2'd1,
    LVL_HIGH = 2'd2
  } level_e;

  // Event class codes
  typedef enum logic [EV_W-1:0] {
    EV_NONE   = 3'd0,
    EV_R      = 3'd1,
    EV_S      = 3'd2,
    EV_H      = 3'd3,
    EV_H_HALF = 3'd4
  } event_e;

  // Divider jobs
  typedef enum logic [1:0] {
    DIV_WIDTH = 2'd0,
    DIV_RATE  = 2'd1
  } div_op_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_AVG,
    ST_HALF,
    ST_SQUARE,
    ST_DECIDE,
    ST_CHECK,
    ST_W_MUL,
    ST_W_DIV,
    ST_W_WAIT,
    ST_RATE_CHK,
    ST_R_MUL,
    ST_R_DIV,
    ST_R_WAIT,
    ST_FINISH
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    accept;
    logic    load;
    logic    div_start;
    div_op_e div_op;
    logic    take_avg;
    logic    half;
    logic    square;
    logic    decide;
    logic    w_mul;
    logic    take_width;
    logic    r_mul;
    logic    take_rate;
    logic    commit;
  } psc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic end_chk;
    logic ev_hit;
    logic total_zero;
    logic now_zero;
  } psc_status_t;

  // One result word
  typedef struct packed {
    logic [CNT_W-1:0]  count_r_out;
    logic [CNT_W-1:0]  count_s_out;
    logic [CNT_W-1:0]  count_h_out;
    logic [CNT_W-1:0]  count_total_out;
    logic [WIDE_W-1:0] rate_out;
    logic [WIDE_W-1:0] mean_width_out;
    logic [LVL_W-1:0]  power_level_out;
    logic [LVL_W-1:0]  slope_level_out;
    logic [EV_W-1:0]   event_class;
  } psc_result_t;

endpackage
`default_nettype wire

>>> hw/rtl/psc_in_if.sv
// Interface: sample input channel.
`default_nettype none
interface psc_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic [15:0]            time_now;
  logic [15:0]            pulse_start;

  modport source (output valid, output sample, output time_now, output pulse_start,
                  input ready);
  modport sink (input valid, input sample, input time_now, input pulse_start,
                output ready);
endinterface
`default_nettype wire

>>> hw/rtl/psc_out_if.sv
// Interface: classification result channel.
`default_nettype none
interface psc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] count_r_out;
  logic [15:0] count_s_out;
  logic [15:0] count_h_out;
  logic [15:0] count_total_out;
  logic [31:0] rate_out;
  logic [31:0] mean_width_out;
  logic [1:0]  power_level_out;
  logic [1:0]  slope_level_out;
  logic [2:0]  event_class;

  modport source (output valid, output count_r_out, output count_s_out,
                  output count_h_out, output count_total_out, output rate_out,
                  output mean_width_out, output power_level_out,
                  output slope_level_out, output event_class, input ready);
  modport sink (input valid, input count_r_out, input count_s_out,
                input count_h_out, input count_total_out, input rate_out,
                input mean_width_out, input power_level_out,
                input slope_level_out, input event_class, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/psc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module psc_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/psc_div.sv
// Restoring divider, one quotient bit per cycle, left-aligned dividend.
`default_nettype none
module psc_div
  import psc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIV_W-1:0]  dividend_i,
  input  wire logic [DVS_W-1:0]  divisor_i,
  input  wire logic [STEP_W-1:0] steps_i,
  output logic                   done_o,
  output logic [DIV_W-1:0]       quotient_o
);
  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DVS_W:0]    rem_q, rem_d, shifted;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DVS_W-1:0]  dvs_q;
  logic              fits;

  // One shift-subtract step
  always_comb begin
    shifted = {rem_q[DVS_W-1:0], quo_q[DIV_W-1]};
    fits    = shifted >= {1'b0, dvs_q};
    rem_d   = fits ? shifted - {1'b0, dvs_q} : shifted;
    quo_d   = {quo_q[DIV_W-2:0], fits};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Operands
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

>>> hw/rtl/psc_dp.sv
// Datapath: window sum, divider, power and slope levels, counts and outputs.
`default_nettype none
module psc_dp
  import psc_pkg::*;
#(
  parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic [TIME_W-1:0]      time_now_i,
  input  wire logic [TIME_W-1:0]      pulse_start_i,
  input  wire psc_cmd_t               cmd_i,
  output psc_status_t                 status_o,
  output psc_result_t                 result_o
);
  localparam int IDX_W = $clog2(WINDOW_LEN);
  localparam int SUM_W = SAMPLE_BITS + IDX_W;
  localparam int H_W   = SAMPLE_BITS - 1;
  localparam int SQ_W  = (2 * H_W > PLIM_W) ? 2 * H_W : PLIM_W;
  localparam int SLP_W = (SAMPLE_BITS + 1 > SLIM_W + 1) ? SAMPLE_BITS + 1 : SLIM_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);

  // Configuration registers
  logic [PLIM_W-1:0] phigh_q, plow_q;
  logic [SLIM_W-1:0] shigh_q, slow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phigh_q <= POWER_HIGH_RST;
      plow_q  <= POWER_LOW_RST;
      shigh_q <= SLOPE_HIGH_RST;
      slow_q  <= SLOPE_LOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_POWER_HIGH: phigh_q <= cfg_data_i;
        CFG_POWER_LOW:  plow_q  <= cfg_data_i;
        CFG_SLOPE_HIGH: shigh_q <= cfg_data_i[SLIM_W-1:0];
        CFG_SLOPE_LOW:  slow_q  <= cfg_data_i[SLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Word capture
  logic [SAMPLE_BITS-1:0] smp_q;
  logic [TIME_W-1:0]      now_q, start_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      smp_q   <= sample_i;
      now_q   <= time_now_i;
      start_q <= pulse_start_i;
    end
  end

  // Sample window; entries past the fill point read as zero
  logic [IDX_W-1:0]       wi_q;
  logic                   filled_q;
  logic [SAMPLE_BITS-1:0] ring_rd, old_smp;
  logic [SUM_W-1:0]       sum_q;

  psc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_LEN)) u_ring (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load),
    .waddr_i(wi_q),
    .wdata_i(smp_q),
    .re_i   (cmd_i.accept),
    .raddr_i(wi_q),
    .rdata_o(ring_rd)
  );

  assign old_smp = filled_q ? ring_rd : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (cmd_i.load) begin
      sum_q <= sum_q - SUM_W'(old_smp) + SUM_W'(smp_q);
    end
  end

  // Shared divider
  logic [DIV_W-1:0]  div_num, quo;
  logic [DVS_W-1:0]  div_dvs;
  logic [STEP_W-1:0] div_steps;
  logic              div_done;
  logic [PROD_W-1:0] prod_q;
  logic [TD_W-1:0]   td_q;
  logic [CNT_W-1:0]  cnt_r_q, cnt_s_q, cnt_h_q, cnt_t_q;

  always_comb begin
    case (cmd_i.div_op)
      DIV_WIDTH: begin
        div_num   = DIV_W'(prod_q) + DIV_W'(td_q);
        div_dvs   = cnt_t_q;
        div_steps = STEP_W'(DIV_W);
      end
      DIV_RATE: begin
        div_num   = {prod_q[WIDE_W-1:0], {(DIV_W - WIDE_W){1'b0}}};
        div_dvs   = now_q;
        div_steps = STEP_W'(WIDE_W);
      end
      default: begin
        div_num   = '0;
        div_dvs   = '0;
        div_steps = '0;
      end
    endcase
  end

  psc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(div_num),
    .divisor_i (div_dvs),
    .steps_i   (div_steps),
    .done_o    (div_done),
    .quotient_o(quo)
  );

  // Average, half excess and squared power
  logic [SAMPLE_BITS-1:0] avg_q, baseline_q, avg_diff;
  logic [H_W-1:0]         h_q;
  logic [SQ_W-1:0]        sq;
  logic [PLIM_W-1:0]      power_q;

  assign avg_diff = avg_q - baseline_q;
  assign sq       = SQ_W'(h_q) * SQ_W'(h_q);

  always_ff @(posedge clk_i) begin
    // window length is a power of two, so the mean is the upper sum bits
    if (cmd_i.take_avg) begin
      avg_q <= sum_q[SUM_W-1:IDX_W];
    end
    if (cmd_i.half) begin
      h_q <= (avg_q >= baseline_q) ? avg_diff[SAMPLE_BITS-1:1] : '0;
    end
    if (cmd_i.square) begin
      power_q <= (sq > SQ_W'(POWER_MAX)) ? POWER_MAX : sq[PLIM_W-1:0];
    end
  end

  // Level and event decision
  logic [SAMPLE_BITS-1:0] prev_q, d_val;
  level_e                 plat_q, slat_q, plat_up, slat_up;
  logic                   toggle_q, learned, smp_ge, p_hi, p_lo, s_hi, s_lo, end_c;
  logic signed [SLP_W-1:0] slope;
  event_e                 ev, ev_q;
  logic                   end_q;

  always_comb begin
    learned = baseline_q != '0;
    smp_ge  = smp_q >= baseline_q;
    d_val   = smp_q - baseline_q;
    slope   = smp_ge ? $signed(SLP_W'(d_val)) - $signed(SLP_W'(prev_q)) : '0;
    p_hi    = learned && (power_q > phigh_q);
    p_lo    = learned && (power_q > plow_q);
    s_hi    = learned && (slope > $signed(SLP_W'(shigh_q)));
    s_lo    = learned && (slope > $signed(SLP_W'(slow_q)));
    plat_up = p_hi ? LVL_HIGH : ((p_lo && plat_q == LVL_NONE) ? LVL_LOW : plat_q);
    slat_up = s_hi ? LVL_HIGH : ((s_lo && slat_q == LVL_NONE) ? LVL_LOW : slat_q);
    end_c   = !s_hi && !s_lo && (power_q < plow_q);
    ev      = EV_NONE;
    if (end_c) begin
      if (plat_up == LVL_HIGH && slat_up == LVL_HIGH) begin
        ev = EV_R;
      end else if (plat_up == LVL_HIGH && slat_up == LVL_LOW) begin
        ev = EV_S;
      end else if (plat_up == LVL_LOW && slat_up == LVL_HIGH) begin
        ev = toggle_q ? EV_H : EV_H_HALF;
      end
    end
  end

  // Sticky state, counts, window index and baseline
  logic [WIDE_W-1:0] rate_q, mw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plat_q     <= LVL_NONE;
      slat_q     <= LVL_NONE;
      toggle_q   <= 1'b0;
      prev_q     <= '0;
      cnt_r_q    <= '0;
      cnt_s_q    <= '0;
      cnt_h_q    <= '0;
      cnt_t_q    <= '0;
      ev_q       <= EV_NONE;
      end_q      <= 1'b0;
      wi_q       <= '0;
      filled_q   <= 1'b0;
      baseline_q <= '0;
      rate_q     <= '0;
      mw_q       <= '0;
    end else begin
      if (cmd_i.decide) begin
        ev_q  <= ev;
        end_q <= end_c;
        if (smp_ge) begin
          prev_q <= d_val;
        end
        if (ev != EV_NONE) begin
          plat_q <= LVL_NONE;
          slat_q <= LVL_NONE;
        end else begin
          plat_q <= plat_up;
          slat_q <= slat_up;
        end
        case (ev)
          EV_R: begin
            cnt_r_q <= cnt_r_q + 1'b1;
            cnt_t_q <= cnt_t_q + 1'b1;
          end
          EV_S: begin
            cnt_s_q <= cnt_s_q + 1'b1;
            cnt_t_q <= cnt_t_q + 1'b1;
          end
          EV_H: begin
            cnt_h_q  <= cnt_h_q + 1'b1;
            cnt_t_q  <= cnt_t_q + 1'b1;
            toggle_q <= 1'b0;
          end
          EV_H_HALF: toggle_q <= 1'b1;
          default: ;
        endcase
        // window index wraps; first full window sets the baseline
        if (wi_q == LAST_IDX) begin
          wi_q     <= '0;
          filled_q <= 1'b1;
          if (baseline_q == '0) begin
            baseline_q <= avg_q;
          end
        end else begin
          wi_q <= wi_q + 1'b1;
        end
      end
      if (cmd_i.take_width && div_done) begin
        mw_q <= quo[WIDE_W-1:0];
      end
      if (cmd_i.take_rate && div_done) begin
        rate_q <= quo[WIDE_W-1:0];
      end
    end
  end

  // Pulse width in ticks, wrapping at the tick width
  logic [TIME_W-1:0] width_ticks;

  assign width_ticks = now_q - start_q;

  // Products for the width update and the rate
  always_ff @(posedge clk_i) begin
    if (cmd_i.w_mul) begin
      prod_q <= PROD_W'(cnt_t_q - 1'b1) * PROD_W'(mw_q);
      td_q   <= TD_W'(width_ticks) * TD_W'(WIDTH_SCALE);
    end else if (cmd_i.r_mul) begin
      prod_q <= PROD_W'(cnt_t_q) * PROD_W'(RATE_SCALE);
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      result_o.count_r_out     <= cnt_r_q;
      result_o.count_s_out     <= cnt_s_q;
      result_o.count_h_out     <= cnt_h_q;
      result_o.count_total_out <= cnt_t_q;
      result_o.rate_out        <= rate_q;
      result_o.mean_width_out  <= mw_q;
      result_o.power_level_out <= plat_q;
      result_o.slope_level_out <= slat_q;
      result_o.event_class     <= ev_q;
    end
  end

  // Status
  assign status_o.div_done   = div_done;
  assign status_o.end_chk    = end_q;
  assign status_o.ev_hit     = ev_q != EV_NONE;
  assign status_o.total_zero = cnt_t_q == '0;
  assign status_o.now_zero   = now_q == '0;
endmodule
`default_nettype wire

>>> hw/rtl/psc_ctrl.sv
// Controller: sequences one sample word through the datapath.
`default_nettype none
module psc_ctrl
  import psc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire psc_status_t status_i,
  output psc_cmd_t         cmd_o,
  output state_e           state_o
);
  state_e state_q, state_d;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD:     state_d = ST_AVG;
      ST_AVG:      state_d = ST_HALF;
      ST_HALF:     state_d = ST_SQUARE;
      ST_SQUARE:   state_d = ST_DECIDE;
      ST_DECIDE:   state_d = ST_CHECK;
      ST_CHECK: begin
        if (!status_i.end_chk) begin
          state_d = ST_FINISH;
        end else if (status_i.ev_hit && !status_i.total_zero) begin
          state_d = ST_W_MUL;
        end else begin
          state_d = ST_RATE_CHK;
        end
      end
      ST_W_MUL:    state_d = ST_W_DIV;
      ST_W_DIV:    state_d = ST_W_WAIT;
      ST_W_WAIT:   if (status_i.div_done) state_d = ST_RATE_CHK;
      ST_RATE_CHK: state_d = status_i.now_zero ? ST_FINISH : ST_R_MUL;
      ST_R_MUL:    state_d = ST_R_DIV;
      ST_R_DIV:    state_d = ST_R_WAIT;
      ST_R_WAIT:   if (status_i.div_done) state_d = ST_FINISH;
      ST_FINISH:   if (slot_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.div_op     = DIV_WIDTH;
    cmd_o.accept     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.load       = state_q == ST_LOAD;
    cmd_o.take_avg   = state_q == ST_AVG;
    cmd_o.half       = state_q == ST_HALF;
    cmd_o.square     = state_q == ST_SQUARE;
    cmd_o.decide     = state_q == ST_DECIDE;
    cmd_o.w_mul      = state_q == ST_W_MUL;
    cmd_o.take_width = state_q == ST_W_WAIT;
    cmd_o.r_mul      = state_q == ST_R_MUL;
    cmd_o.take_rate  = state_q == ST_R_WAIT;
    cmd_o.commit     = (state_q == ST_FINISH) && slot_free;
    case (state_q)
      ST_W_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_WIDTH;
      end
      ST_R_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_RATE;
      end
      default: ;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign state_o     = state_q;
endmodule
`default_nettype wire

>>> hw/rtl/pulse_shape_classifier.sv
// Top level: pulse shape classifier.
// Takes one converter sample per word and returns one result word per sample:
// event counts, rate, running mean pulse width, the two sticky levels and the
// event class. A word with no pulse end passes through accept, window update,
// mean, half excess, square, decide, check and finish. A pulse end adds a
// 32-step rate division, and when a pulse is classified and the mean width is
// updated, a 49-step division runs before it. Both divisions share one
// radix-2 divider; a zero tick count skips the rate division, and a result
// held by the receiver stalls the word in the finish state. The window mean
// is taken from the upper bits of the running sum, so WINDOW_LEN must be a
// power of two. The next sample is taken while the previous result waits in
// the output register. No clearing pass runs after reset; the window RAM is
// tracked by its fill point.
`default_nettype none
module pulse_shape_classifier
  import psc_pkg::*;
#(
  parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  psc_in_if.sink                     in_i,
  psc_out_if.source                  out_o
);
  psc_cmd_t    cmd;
  psc_status_t status;
  psc_result_t result;
  state_e      state;

  psc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .status_i   (status),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  psc_dp #(.WINDOW_LEN(WINDOW_LEN), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sample_i     (in_i.sample),
    .time_now_i   (in_i.time_now),
    .pulse_start_i(in_i.pulse_start),
    .cmd_i        (cmd),
    .status_o     (status),
    .result_o     (result)
  );

  assign out_o.count_r_out     = result.count_r_out;
  assign out_o.count_s_out     = result.count_s_out;
  assign out_o.count_h_out     = result.count_h_out;
  assign out_o.count_total_out = result.count_total_out;
  assign out_o.rate_out        = result.rate_out;
  assign out_o.mean_width_out  = result.mean_width_out;
  assign out_o.power_level_out = result.power_level_out;
  assign out_o.slope_level_out = result.slope_level_out;
  assign out_o.event_class     = result.event_class;

`ifndef ASSERT_OFF
  // Divider finishes only while the controller waits for it
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_done |-> (state == ST_W_WAIT || state == ST_R_WAIT))
    else $error("divider done outside a wait state");

  // A new result appears only out of the finish state
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside finish");

  // Levels clear whenever an event is reported
  a_event_clears_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.event_class != EV_NONE) |->
      (out_o.power_level_out == LVL_NONE && out_o.slope_level_out == LVL_NONE))
    else $error("levels not cleared on event");
`endif
endmodule
`default_nettype wire
